>>> src/stlb_pkg.sv
// Shared types, codes and constants for the segment TLB refill block.
package stlb_pkg;

  localparam int TLB_SLOTS   = 64;
  localparam int STACK_PAGES = 12;
  localparam longint STACK_TOP_VAL = 64'd2147483648;
  localparam int PAGE_SHIFT  = 12;

  localparam int SLOT_W = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;

  localparam logic [31:0] PAGE_MASK  = ~((32'd1 << PAGE_SHIFT) - 32'd1);
  localparam logic [31:0] STACK_TOP  = 32'(STACK_TOP_VAL);
  localparam logic [31:0] STACK_SPAN = 32'(longint'(STACK_PAGES) << PAGE_SHIFT);
  localparam logic [31:0] STACK_BASE = STACK_TOP - STACK_SPAN;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_RO    = 3'd2,
    CMD_ACT   = 3'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CMD  = 3'd1,
    ST_RO_FAULT = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_BAD_ADDR = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_FILL    = 2'd1,
    EV_REPLACE = 2'd2,
    EV_FLUSH   = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    REG_CODE_VBASE  = 3'd0,
    REG_CODE_PAGES  = 3'd1,
    REG_CODE_PBASE  = 3'd2,
    REG_DATA_VBASE  = 3'd3,
    REG_DATA_PAGES  = 3'd4,
    REG_DATA_PBASE  = 3'd5,
    REG_STACK_PBASE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] code_vbase;
    logic [19:0] code_pages;
    logic [31:0] code_pbase;
    logic [31:0] data_vbase;
    logic [19:0] data_pages;
    logic [31:0] data_pbase;
    logic [31:0] stack_pbase;
  } seg_cfg_t;

  typedef struct packed {
    logic        hit;
    logic        writable;
    logic [31:0] frame;
  } map_res_t;

  typedef struct packed {
    logic fill;
    logic flush;
  } alloc_req_t;

  typedef struct packed {
    logic              replace;
    logic [SLOT_W-1:0] slot;
  } alloc_resp_t;

endpackage

>>> src/stlb_seg_map.sv
// Segment lookup: maps a virtual page through code, data and stack segments.
module stlb_seg_map import stlb_pkg::*; (
  input  logic [31:0] page,
  input  seg_cfg_t    cfg,
  output map_res_t    res
);

  logic [31:0] cb, db, ct, dt;
  logic        in_code, in_data, in_stack;

  always_comb begin
    cb = cfg.code_vbase & PAGE_MASK;
    db = cfg.data_vbase & PAGE_MASK;
    // span wraps to 32 bits, as does the top
    ct = cb + 32'({cfg.code_pages, 32'd0} >> (32 - PAGE_SHIFT));
    dt = db + 32'({cfg.data_pages, 32'd0} >> (32 - PAGE_SHIFT));
    in_code  = (page >= cb) && (page < ct);
    in_data  = (page >= db) && (page < dt);
    in_stack = (page >= STACK_BASE) && (page < STACK_TOP);
  end

  always_comb begin
    res = '0;
    if (in_code) begin
      res.hit   = 1'b1;
      res.frame = (page - cb) + (cfg.code_pbase & PAGE_MASK);
    end else if (in_data) begin
      res.hit      = 1'b1;
      res.writable = 1'b1;
      res.frame    = (page - db) + (cfg.data_pbase & PAGE_MASK);
    end else if (in_stack) begin
      res.hit      = 1'b1;
      res.writable = 1'b1;
      res.frame    = (page - STACK_BASE) + (cfg.stack_pbase & PAGE_MASK);
    end
  end

endmodule

>>> src/stlb_slot_alloc.sv
// TLB slot bookkeeping: valid bits, first-free search and round-robin victim.
module stlb_slot_alloc import stlb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  alloc_req_t  req,
  output alloc_resp_t resp
);

  logic [TLB_SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOT_W-1:0]    vp_r, vp_nxt;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;

  // lowest free slot wins: scan downwards so the last hit is the lowest
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    resp.replace = !free_found;
    resp.slot    = free_found ? free_idx : vp_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    vp_nxt    = vp_r;
    if (req.flush) begin
      valid_nxt = '0;
    end else if (req.fill) begin
      valid_nxt[resp.slot] = 1'b1;
      if (!free_found) begin
        vp_nxt = (vp_r == SLOT_W'(TLB_SLOTS - 1)) ? '0 : vp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vp_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      vp_r    <= vp_nxt;
    end
  end

endmodule

>>> src/segment_tlb_refill_core.sv
// Top level of the segment TLB refill block: registers, decode and result stage.
//
//  channel | ports                                          | direction
//  in      | in_valid/in_ready, in_command, in_fault_address, in_space_id | to block
//  out     | out_valid/out_ready, out_status, out_event_kind, out_virtual_page,
//          | out_physical_frame, out_writable, out_slot_index | from block
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data       | to block
//
// A beat taken on in waits in the input register and moves into the result register
// when out is free to take it; one beat per cycle is sustained while out is drained.
// Segment compares, translation and the first-free search over the valid bits are
// all in that single stage. Reset clears the valid bits, victim pointer, active
// space and config registers. A stall on out holds both stages.
module segment_tlb_refill_core import stlb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_fault_address,
  input  logic [7:0]  in_space_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_event_kind,
  output logic [31:0] out_virtual_page,
  output logic [31:0] out_physical_frame,
  output logic        out_writable,
  output logic [5:0]  out_slot_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  seg_cfg_t cfg_r, cfg_nxt;
  logic [7:0] active_r, active_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic [2:0]  s1_cmd_r;
  logic [31:0] s1_addr_r;
  logic [7:0]  s1_sid_r;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, status_c;
  event_t      out_event_r, event_c;
  logic [31:0] out_page_r, page_c;
  logic [31:0] out_frame_r, frame_c;
  logic        out_wr_r, wr_c;
  logic [5:0]  out_slot_r, slot_c;

  logic        commit;
  logic [31:0] page;
  map_res_t    map_res;
  alloc_req_t  alloc_req;
  alloc_resp_t alloc_resp;
  logic        do_fill, do_flush;

  assign commit   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || commit;
  assign cfg_ready = 1'b1;
  assign page     = s1_addr_r & PAGE_MASK;

  stlb_seg_map u_map (
    .page (page),
    .cfg  (cfg_r),
    .res  (map_res)
  );

  stlb_slot_alloc u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alloc_req),
    .resp  (alloc_resp)
  );

  // command decode and result assembly
  always_comb begin
    status_c = ST_OK;
    event_c  = EV_NONE;
    page_c   = '0;
    frame_c  = '0;
    wr_c     = 1'b0;
    slot_c   = '0;
    do_fill  = 1'b0;
    do_flush = 1'b0;
    case (s1_cmd_r)
      CMD_ACT: begin
        if (s1_sid_r != active_r) begin
          do_flush = 1'b1;
          event_c  = EV_FLUSH;
        end
      end
      CMD_RO: begin
        status_c = ST_RO_FAULT;
      end
      CMD_READ, CMD_WRITE: begin
        if (active_r == '0) begin
          status_c = ST_NO_SPACE;
        end else if (!map_res.hit) begin
          status_c = ST_BAD_ADDR;
        end else begin
          do_fill = 1'b1;
          event_c = alloc_resp.replace ? EV_REPLACE : EV_FILL;
          page_c  = page;
          frame_c = map_res.frame;
          wr_c    = map_res.writable;
          slot_c  = 6'(alloc_resp.slot);
        end
      end
      default: begin
        status_c = ST_BAD_CMD;
      end
    endcase
  end

  always_comb begin
    alloc_req.fill  = commit && do_fill;
    alloc_req.flush = commit && do_flush;
  end

  always_comb begin
    active_nxt = active_r;
    if (commit && (s1_cmd_r == CMD_ACT)) begin
      active_nxt = s1_sid_r;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CODE_VBASE:  cfg_nxt.code_vbase  = cfg_data;
        REG_CODE_PAGES:  cfg_nxt.code_pages  = cfg_data[19:0];
        REG_CODE_PBASE:  cfg_nxt.code_pbase  = cfg_data;
        REG_DATA_VBASE:  cfg_nxt.data_vbase  = cfg_data;
        REG_DATA_PAGES:  cfg_nxt.data_pages  = cfg_data[19:0];
        REG_DATA_PBASE:  cfg_nxt.data_pbase  = cfg_data;
        REG_STACK_PBASE: cfg_nxt.stack_pbase = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (commit) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      active_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      active_r    <= active_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_addr_r <= in_fault_address;
      s1_sid_r  <= in_space_id;
    end
    if (commit) begin
      out_status_r <= status_c;
      out_event_r  <= event_c;
      out_page_r   <= page_c;
      out_frame_r  <= frame_c;
      out_wr_r     <= wr_c;
      out_slot_r   <= slot_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_event_kind     = out_event_r;
  assign out_virtual_page   = out_page_r;
  assign out_physical_frame = out_frame_r;
  assign out_writable       = out_wr_r;
  assign out_slot_index     = out_slot_r;

endmodule
